### rtl/core/spfa_pkg.sv
// Shared types and constants for the single-precision adder pipeline.
package spfa_pkg;
  localparam logic [23:0] HIDDEN_BIT = 24'h800000;
  localparam logic [7:0] EXP_MAX = 8'd255;
  localparam int SUBN_LIMIT = -23;

  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_word;
    logic [9:0]  exp;
    logic signed [25:0] sum;
  } align_t;

  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_word;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;
    logic [23:0] mag;
  } norm_t;
endpackage

### rtl/core/single_precision_float_adder_top.sv
// Three-stage pipelined truncating single-precision adder.
// Throughput: one transfer per cycle unless the output stalls; align, normalize and pack stages
// each end in a register and advance together when the output is free.
// Reset clears all stage valid bits; data registers are not reset.
module single_precision_float_adder_top import spfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] a_word,
  input  logic [31:0] b_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sum_word
);
  align_t a_c, a_r;
  norm_t  n_c, n_r;
  logic [31:0] w_c;
  logic v1, v2, adv;

  spfa_align u_align (.a_word(a_word), .b_word(b_word), .res(a_c));
  spfa_norm  u_norm  (.in(a_r), .res(n_c));
  spfa_pack  u_pack  (.in(n_r), .word(w_c));

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_c;
      n_r <= n_c;
      sum_word <= w_c;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum_word))
    else $error("output changed while stalled");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("transfer lost at stage one");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");
`endif
endmodule

### rtl/core/spfa_align.sv
// Operand unpack, exponent compare, alignment shift, signed add and zero-operand bypass.
module spfa_align import spfa_pkg::*; (
  input  logic [31:0] a_word,
  input  logic [31:0] b_word,
  output align_t      res
);
  logic [7:0]  ea, eb, d;
  logic [23:0] ma, mb, sa_m, sb_m;
  logic signed [25:0] va, vb;
  always_comb begin
    ea = a_word[30:23];
    eb = b_word[30:23];
    ma = {1'b1, a_word[22:0]};
    mb = {1'b1, b_word[22:0]};
    sa_m = ma;
    sb_m = mb;
    if (ea > eb) begin
      d = ea - eb;
      sb_m = (d >= 8'd25) ? 24'd0 : (mb >> d);
      res.exp = {2'b00, ea};
    end else begin
      d = eb - ea;
      sa_m = (d >= 8'd25) ? 24'd0 : (ma >> d);
      res.exp = {2'b00, eb};
    end
    va = a_word[31] ? -$signed({2'b00, sa_m}) : $signed({2'b00, sa_m});
    vb = b_word[31] ? -$signed({2'b00, sb_m}) : $signed({2'b00, sb_m});
    res.sum = va + vb;
    res.bypass = 1'b0;
    res.bypass_word = 32'd0;
    if (a_word[30:0] == 31'd0) begin
      res.bypass = 1'b1;
      res.bypass_word = b_word;
    end else if (b_word[30:0] == 31'd0) begin
      res.bypass = 1'b1;
      res.bypass_word = a_word;
    end
  end
endmodule

### rtl/core/spfa_norm.sv
// Sign extraction, zero detection, carry handling and leading-one normalization.
module spfa_norm import spfa_pkg::*; (
  input  align_t in,
  output norm_t  res
);
  logic [24:0] mag;
  logic [24:0] m;
  logic [4:0]  lz;
  always_comb begin
    mag = in.sum[25] ? 25'(-in.sum) : 25'(in.sum);
    res.bypass = in.bypass;
    res.bypass_word = in.bypass_word;
    res.zero = (in.sum == 26'sd0);
    res.sign = in.sum[25];
    res.exp = $signed({1'b0, in.exp});
    m = mag;
    if (m[24]) begin
      m = m >> 1;
      res.exp = res.exp + 11'sd1;
    end
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    res.mag = m[23:0] << lz;
    res.exp = res.exp - $signed({6'd0, lz});
  end
endmodule

### rtl/core/spfa_pack.sv
// Overflow, underflow and result word packing.
module spfa_pack import spfa_pkg::*; (
  input  norm_t       in,
  output logic [31:0] word
);
  logic [4:0] sh;
  always_comb begin
    sh = 5'(11'sd1 - in.exp);
    if (in.bypass) begin
      word = in.bypass_word;
    end else if (in.zero) begin
      word = 32'd0;
    end else if (in.exp >= $signed({3'b000, EXP_MAX})) begin
      word = {in.sign, EXP_MAX, 23'd0};
    end else if (in.exp <= 11'sd0) begin
      if (in.exp < 11'(SUBN_LIMIT)) word = {in.sign, 31'd0};
      else word = {in.sign, 8'd0, 23'(in.mag >> sh)};
    end else begin
      word = {in.sign, in.exp[7:0], in.mag[22:0]};
    end
  end
endmodule

### test/tb_single_precision_float_adder_top.sv
// Testbench for the truncating single-precision adder: directed table plus random sums.
module tb_single_precision_float_adder_top;
  import spfa_pkg::*;

  localparam int N_RANDOM = 900;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    logic [31:0] sum;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] a_word = '0;
  logic [31:0] b_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sum_word;

  logic [31:0] sum_queue[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  int          got_count = 0;
  bit          hold_rx = 1'b0;
  bit          stim_done = 1'b0;
  vec_t        vectors[$];

  single_precision_float_adder_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a_word(a_word), .b_word(b_word), .out_valid(out_valid),
    .out_ready(out_ready), .sum_word(sum_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] trunc_add(logic [31:0] a, logic [31:0] b);
    logic [23:0] ma, mb, frac;
    logic [7:0]  ea, eb;
    int          d, e, va, vb, s;
    logic [31:0] mag;
    logic        sg;
    ea = a[30:23];
    eb = b[30:23];
    if (ea == 0 && a[22:0] == 0) return b;
    if (eb == 0 && b[22:0] == 0) return a;
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
    if (ea > eb) begin
      d = int'(ea) - int'(eb);
      mb = (d >= 25) ? 24'd0 : (mb >> d);
      e = int'(ea);
    end else begin
      d = int'(eb) - int'(ea);
      ma = (d >= 25) ? 24'd0 : (ma >> d);
      e = int'(eb);
    end
    va = a[31] ? -int'(ma) : int'(ma);
    vb = b[31] ? -int'(mb) : int'(mb);
    s = va + vb;
    if (s == 0) return 32'd0;
    sg = s < 0;
    mag = sg ? -s : s;
    if (mag[24]) begin
      mag = mag >> 1;
      e++;
    end
    while (!mag[23]) begin
      mag = mag << 1;
      e--;
    end
    if (e >= int'(EXP_MAX)) return {sg, EXP_MAX, 23'd0};
    if (e <= 0) begin
      if (e < SUBN_LIMIT) return {sg, 31'd0};
      frac = mag[23:0] >> (1 - e);
      return {sg, 8'd0, frac[22:0]};
    end
    return {sg, e[7:0], mag[22:0]};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, got_count);
    err_count++;
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'd0;
      1: w[30:23] = 8'd255;
      2: w[30:0] = 31'd0;
      3: w[30:23] = 8'($urandom_range(250, 254));
      default: ;
    endcase
    return w;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic add_vec(logic [31:0] a, logic [31:0] b, logic known, logic [31:0] s);
    vec_t v;
    v.a = a;
    v.b = b;
    v.known = known;
    v.sum = s;
    vectors.push_back(v);
  endtask

  task automatic send_one(logic [31:0] a, logic [31:0] b, logic [31:0] want);
    a_word <= a;
    b_word <= b;
    in_valid <= 1'b1;
    sum_queue.push_back(want);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("single_precision_float_adder_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (sum_queue.size() == 0) begin
        report_mismatch("unexpected", sum_word, 32'hx);
      end else begin
        if (sum_word !== sum_queue[0]) report_mismatch("sum_word", sum_word, sum_queue[0]);
        void'(sum_queue.pop_front());
      end
      got_count++;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (!stim_done && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int hold_cycles;
    int wait_cycles;
    logic [31:0] a, b;
    add_vec(32'h0000_0000, 32'h3f80_0000, 1, 32'h3f80_0000);
    add_vec(32'h8000_0000, 32'hc040_0000, 1, 32'hc040_0000);
    add_vec(32'h4000_0000, 32'h0000_0000, 1, 32'h4000_0000);
    add_vec(32'h7fc0_0001, 32'h8000_0000, 1, 32'h7fc0_0001);
    add_vec(32'h3f80_0000, 32'hbf80_0000, 1, 32'h0000_0000);
    add_vec(32'hc120_0000, 32'h4120_0000, 1, 32'h0000_0000);
    add_vec(32'h7f7f_ffff, 32'h7f7f_ffff, 1, 32'h7f80_0000);
    add_vec(32'hff7f_ffff, 32'hff00_0000, 1, 32'hff80_0000);
    add_vec(32'h3f80_0000, 32'h3f80_0000, 1, 32'h4000_0000);
    add_vec(32'h3f80_0000, 32'h3300_0000, 0, 0);
    add_vec(32'h3f80_0000, 32'h3280_0000, 0, 0);
    add_vec(32'h3f80_0000, 32'h0000_0001, 0, 0);
    add_vec(32'h0080_0000, 32'h8000_0001, 0, 0);
    add_vec(32'h0000_0001, 32'h0000_0001, 0, 0);
    add_vec(32'h0000_0001, 32'h8000_0002, 0, 0);
    add_vec(32'h0100_0000, 32'h80ff_ffff, 0, 0);
    add_vec(32'h7f80_0000, 32'h7f80_0000, 0, 0);
    add_vec(32'hffff_ffff, 32'h7fff_ffff, 0, 0);
    add_vec(32'h3fff_ffff, 32'h3fff_ffff, 0, 0);
    add_vec(32'h4000_0000, 32'hbfff_ffff, 0, 0);
    add_vec(32'hffff_ffff, 32'hffff_ffff, 0, 0);
    add_vec(32'h5555_5555, 32'haaaa_aaaa, 0, 0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vectors[i]) begin
      send_one(vectors[i].a, vectors[i].b,
               vectors[i].known ? vectors[i].sum : trunc_add(vectors[i].a, vectors[i].b));
      idle_sender($urandom_range(0, 1));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      a = rand_word();
      if ($urandom_range(0, 3) == 0) begin
        b = {~a[31], a[30:23] - 8'($urandom_range(0, 2)), 23'($urandom)};
        if ($urandom_range(0, 1)) b[22:0] = a[22:0];
      end else begin
        b = rand_word();
      end
      if (i == 300) begin
        hold_rx = 1'b1;
        fork
          begin
            hold_cycles = 0;
            while (hold_cycles < 60) begin
              @(posedge clk);
              hold_cycles++;
            end
            hold_rx = 1'b0;
          end
        join_none
      end
      if (i == 600) begin
        in_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
      end
      send_one(a, b, trunc_add(a, b));
      if ($urandom_range(0, 2) == 0) idle_sender(gap_len());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (sum_queue.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 10) begin
      @(posedge clk);
      wait_cycles++;
    end
    $display("covered %0d transfers in, %0d sums out: zero bypass, cancellation,", sent_count,
             got_count);
    $display("carry, overflow, subnormal underflow, wide shifts, NaN/inf as ordinary words");
    if (err_count == 0 && sum_queue.size() == 0) begin
      $display("single_precision_float_adder_top regression: pass");
    end else begin
      $display("single_precision_float_adder_top regression: fail");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/spfa_pkg.sv
rtl/core/spfa_align.sv
rtl/core/spfa_norm.sv
rtl/core/spfa_pack.sv
rtl/core/single_precision_float_adder_top.sv
test/tb_single_precision_float_adder_top.sv
